// ===== hw/rtl/wzi_pkg.sv =====
package wzi_pkg;

    // default zone table depth
    localparam int MAX_ZONES_DEF = 8;

    // payload and register widths
    localparam int POS_W      = 13;
    localparam int SCR_W      = 12;
    localparam int ZCNT_W     = 4;
    localparam int LIM_W      = 15;
    localparam int VAL_W      = 16;
    localparam int RAND_W     = 16;
    localparam int ZIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // interpolation datapath
    localparam int ACC_W  = 30;
    localparam int DIV_DW = 28;
    localparam int DIV_VW = 13;

    // request codes
    localparam logic [1:0] REQ_QUERY   = 2'd0;
    localparam logic [1:0] REQ_PERTURB = 2'd1;
    localparam logic [1:0] REQ_SET     = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_ZONES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_ZONES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT = 3'd5;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
        logic       ack;
    } lane_ctl_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] value;
    } lane_rsp_t;

endpackage

// ===== hw/rtl/wzi_ram.sv =====
module wzi_ram #(
    parameter int WIDTH = wzi_pkg::VAL_W,
    parameter int DEPTH = wzi_pkg::MAX_ZONES_DEF
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/wzi_div.sv =====
module wzi_div #(
    parameter int DW = wzi_pkg::DIV_DW,
    parameter int VW = wzi_pkg::DIV_VW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [VW:0]   shifted;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign shifted  = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

endmodule

// ===== hw/rtl/wzi_lane.sv =====
module wzi_lane #(
    parameter int MAX_ZONES = wzi_pkg::MAX_ZONES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wzi_pkg::lane_ctl_t                   ctl,
    input  logic signed [wzi_pkg::POS_W-1:0]     pos,
    input  logic [wzi_pkg::SCR_W-1:0]            screen,
    input  logic [wzi_pkg::ZCNT_W-1:0]           zones,
    input  logic [wzi_pkg::LIM_W-1:0]            wind_limit,
    input  logic [wzi_pkg::LIM_W-1:0]            change_limit,
    input  logic [wzi_pkg::ZIDX_W-1:0]           zone_index,
    input  logic [wzi_pkg::RAND_W-1:0]           rand_sample,
    input  logic signed [wzi_pkg::VAL_W-1:0]     load_value,
    output wzi_pkg::lane_rsp_t                   rsp
);

    localparam int IW   = MAX_ZONES > 1 ? $clog2(MAX_ZONES) : 1;
    localparam int ZW   = $clog2(MAX_ZONES + 1);
    localparam int SW   = wzi_pkg::SCR_W;
    localparam int PW   = IW + SW;
    localparam int VW   = wzi_pkg::VAL_W;
    localparam int AW   = wzi_pkg::ACC_W;
    localparam int DW   = wzi_pkg::DIV_DW;
    localparam int DVW  = wzi_pkg::DIV_VW;
    localparam int LW   = wzi_pkg::LIM_W;
    localparam int RW   = wzi_pkg::RAND_W;
    localparam int MW   = RW + LW;
    localparam int CLW  = VW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SIZE    = 4'd1;
    localparam logic [3:0] S_SEARCH  = 4'd2;
    localparam logic [3:0] S_RD_LO   = 4'd3;
    localparam logic [3:0] S_MUL_LO  = 4'd4;
    localparam logic [3:0] S_MUL_HI  = 4'd5;
    localparam logic [3:0] S_QSTART  = 4'd6;
    localparam logic [3:0] S_QDIV    = 4'd7;
    localparam logic [3:0] S_UPD_RD  = 4'd8;
    localparam logic [3:0] S_UPD_WR  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]            state_reg;
    logic [1:0]            op_reg;
    logic [SW-1:0]         x_reg;
    logic [SW-1:0]         scr_reg;
    logic [ZW-1:0]         ze_reg;
    logic [SW-1:0]         size_reg;
    logic [IW-1:0]         i_reg;
    logic [IW-1:0]         hi_reg;
    logic [DVW-1:0]        a_reg;
    logic [DVW-1:0]        b_reg;
    logic                  exact_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [VW-1:0]  vlo_reg;
    logic signed [VW-1:0]  res_reg;
    logic [IW-1:0]         zi_reg;
    logic [RW-1:0]         rand_reg;
    logic signed [VW-1:0]  load_reg;
    logic [MW-1:0]         prod_reg;
    logic [MAX_ZONES-1:0]  vld_reg;
    logic                  rd_vld_reg;

    logic [SW-1:0]         scr_eff;
    logic [ZW-1:0]         ze_w;
    logic [SW-1:0]         x_w;
    logic [PW-1:0]         prod_w;
    logic                  found;
    logic                  last;
    logic [PW-1:0]         b_w;
    logic [IW-1:0]         raddr;
    logic [VW-1:0]         ram_rdata;
    logic signed [VW-1:0]  rdq;
    logic                  div_start;
    logic                  div_busy;
    logic [DW-1:0]         div_dividend;
    logic [DVW-1:0]        div_divisor;
    logic [DW-1:0]         div_quo;
    logic                  neg;
    logic signed [AW-1:0]  mag;
    logic [DVW-1:0]        den;
    logic signed [CLW-1:0] delta;
    logic signed [CLW-1:0] sum_w;
    logic signed [CLW-1:0] lim_w;
    logic signed [VW-1:0]  nv;
    logic                  we;
    logic [6:0]            zi_ext;
    logic                  zok;

    // effective extent and zone count
    assign scr_eff = (screen == '0) ? SW'(1) : screen;

    always_comb
    begin
        if (zones == '0)
        begin
            ze_w = ZW'(1);
        end
        else if (32'(zones) > MAX_ZONES)
        begin
            ze_w = ZW'(MAX_ZONES);
        end
        else
        begin
            ze_w = ZW'(zones);
        end
    end

    // clamp position to the screen
    always_comb
    begin
        if (pos < 0)
        begin
            x_w = '0;
        end
        else if (pos >= $signed({1'b0, scr_eff}))
        begin
            x_w = scr_eff - 1'b1;
        end
        else
        begin
            x_w = pos[SW-1:0];
        end
    end

    assign zi_ext = 7'(zone_index);
    assign zok    = 32'(zone_index) < MAX_ZONES;

    // downward zone search, one zone per cycle
    assign prod_w = PW'(i_reg) * PW'(size_reg);
    assign found  = (i_reg == '0) || (PW'(x_reg) > prod_w);
    assign last   = (ZW'(i_reg) + ZW'(1)) == ze_reg;
    assign b_w    = last ? (PW'(scr_reg) - PW'(x_reg))
                         : (prod_w + PW'(size_reg) - PW'(x_reg));

    always_comb
    begin
        unique case (state_reg)
            S_MUL_LO: raddr = hi_reg;
            S_UPD_RD: raddr = zi_reg;
            default:  raddr = i_reg;
        endcase
    end

    // entries never written read as zero
    assign rdq = rd_vld_reg ? $signed(ram_rdata) : '0;

    assign neg = acc_reg < 0;
    assign mag = neg ? -acc_reg : acc_reg;
    assign den = a_reg + b_reg;

    assign div_start    = (state_reg == S_IDLE && ctl.go && ctl.op == wzi_pkg::REQ_QUERY)
                          || (state_reg == S_QSTART && den != '0);
    assign div_dividend = (state_reg == S_QSTART) ? DW'(mag) : DW'(scr_eff);
    assign div_divisor  = (state_reg == S_QSTART) ? den : DVW'(ze_w);

    // perturb delta and clamp
    assign delta = $signed(CLW'(prod_reg[MW-1:LW])) - $signed(CLW'(change_limit));
    assign sum_w = (op_reg == wzi_pkg::REQ_SET) ? CLW'(load_reg) : (CLW'(rdq) + delta);
    assign lim_w = $signed(CLW'(wind_limit));

    always_comb
    begin
        if (sum_w > lim_w)
        begin
            nv = VW'(lim_w);
        end
        else if (sum_w < -lim_w)
        begin
            nv = VW'(-lim_w);
        end
        else
        begin
            nv = VW'(sum_w);
        end
    end

    assign we = state_reg == S_UPD_WR;

    assign rsp.done  = state_reg == S_DONE;
    assign rsp.value = res_reg;

    wzi_div #(
        .DW(DW),
        .VW(DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    wzi_ram #(
        .WIDTH(VW),
        .DEPTH(MAX_ZONES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (zi_reg),
        .wdata (nv),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[zi_reg] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.go)
                    begin
                        if (ctl.op == wzi_pkg::REQ_QUERY)
                        begin
                            state_reg <= S_SIZE;
                        end
                        else if (zok)
                        begin
                            state_reg <= S_UPD_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SIZE:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (found)
                    begin
                        state_reg <= S_RD_LO;
                    end
                end
                S_RD_LO:  state_reg <= S_MUL_LO;
                S_MUL_LO: state_reg <= exact_reg ? S_DONE : S_MUL_HI;
                S_MUL_HI: state_reg <= S_QSTART;
                S_QSTART: state_reg <= (den == '0) ? S_DONE : S_QDIV;
                S_QDIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_UPD_RD: state_reg <= S_UPD_WR;
                S_UPD_WR: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (ctl.ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg <= vld_reg[raddr];
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg   <= ctl.op;
                x_reg    <= x_w;
                scr_reg  <= scr_eff;
                ze_reg   <= ze_w;
                zi_reg   <= zi_ext[IW-1:0];
                rand_reg <= rand_sample;
                load_reg <= load_value;
                res_reg  <= '0;
            end
            S_SIZE:
            begin
                size_reg <= SW'(div_quo);
                i_reg    <= IW'(ze_reg - ZW'(1));
            end
            S_SEARCH:
            begin
                if (found)
                begin
                    a_reg     <= DVW'(PW'(x_reg) - prod_w);
                    b_reg     <= DVW'(b_w);
                    hi_reg    <= last ? '0 : IW'(i_reg + 1'b1);
                    exact_reg <= PW'(x_reg) == prod_w;
                end
                else
                begin
                    i_reg <= i_reg - 1'b1;
                end
            end
            S_MUL_LO:
            begin
                vlo_reg <= rdq;
                res_reg <= rdq;
                acc_reg <= $signed({1'b0, b_reg}) * rdq;
            end
            S_MUL_HI:
            begin
                acc_reg <= acc_reg + $signed({1'b0, a_reg}) * rdq;
            end
            S_QSTART:
            begin
                res_reg <= vlo_reg;
            end
            S_QDIV:
            begin
                if (!div_busy)
                begin
                    res_reg <= neg ? -VW'(div_quo) : VW'(div_quo);
                end
            end
            S_UPD_RD:
            begin
                prod_reg <= MW'(rand_reg) * MW'(change_limit);
            end
            S_UPD_WR:
            begin
                res_reg <= nv;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/wind_zone_interpolator_core.sv =====
// wind zone interpolator: two zone tables of signed 16-bit wind values, one per
// axis, each handled by its own lane. a query beat (req_type 0) clamps pos_x and
// pos_y to the screen, finds each zone and interpolates toward the next zone
// start (the last zone toward zone 0); wind_x and wind_y carry the answers and
// zone_value is 0. a perturb beat (1) adds a scaled random delta to one zone and
// a set beat (2) loads it, both clamped to +-wind_limit; zone_value carries the
// new entry and the wind fields are 0. req_type 3 is dropped with no result.
// one item is in work at a time: a query runs the 28-step iterative divider up to
// twice per lane, once for the zone size and once for the weighted average, plus
// one zone per cycle in the search; perturb and set read and write the entry
// through the lane's table port. the output register lets the next beat in while
// a result waits. tables read as zero after reset.
module wind_zone_interpolator_core #(
    parameter int MAX_ZONES = wzi_pkg::MAX_ZONES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wzi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wzi_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            req_type,
    input  logic signed [wzi_pkg::POS_W-1:0]      pos_x,
    input  logic signed [wzi_pkg::POS_W-1:0]      pos_y,
    input  logic                                  axis_sel,
    input  logic [wzi_pkg::ZIDX_W-1:0]            zone_index,
    input  logic [wzi_pkg::RAND_W-1:0]            rand_sample,
    input  logic signed [wzi_pkg::VAL_W-1:0]      load_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [wzi_pkg::VAL_W-1:0]      wind_x,
    output logic signed [wzi_pkg::VAL_W-1:0]      wind_y,
    output logic signed [wzi_pkg::VAL_W-1:0]      zone_value
);

    localparam int VW = wzi_pkg::VAL_W;

    // configuration registers
    logic [wzi_pkg::SCR_W-1:0]  scr_w_reg;
    logic [wzi_pkg::SCR_W-1:0]  scr_h_reg;
    logic [wzi_pkg::ZCNT_W-1:0] hz_reg;
    logic [wzi_pkg::ZCNT_W-1:0] vz_reg;
    logic [wzi_pkg::LIM_W-1:0]  wl_reg;
    logic [wzi_pkg::LIM_W-1:0]  cl_reg;

    // item control
    logic                       busy_reg;
    logic                       need_x_reg;
    logic                       need_y_reg;
    logic                       query_reg;
    logic                       axis_reg;
    logic                       out_valid_reg;
    logic signed [VW-1:0]       wind_x_reg;
    logic signed [VW-1:0]       wind_y_reg;
    logic signed [VW-1:0]       zone_value_reg;

    logic                       accept;
    logic                       live;
    logic                       is_query;
    logic                       res_ready;
    logic                       load;
    wzi_pkg::lane_ctl_t         ctl_x;
    wzi_pkg::lane_ctl_t         ctl_y;
    wzi_pkg::lane_rsp_t         rsp_x;
    wzi_pkg::lane_rsp_t         rsp_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= wzi_pkg::SCR_W'(640);
            scr_h_reg <= wzi_pkg::SCR_W'(480);
            hz_reg    <= wzi_pkg::ZCNT_W'(3);
            vz_reg    <= wzi_pkg::ZCNT_W'(3);
            wl_reg    <= '0;
            cl_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wzi_pkg::REG_SCREEN_W:     scr_w_reg <= cfg_data[wzi_pkg::SCR_W-1:0];
                wzi_pkg::REG_SCREEN_H:     scr_h_reg <= cfg_data[wzi_pkg::SCR_W-1:0];
                wzi_pkg::REG_H_ZONES:      hz_reg    <= cfg_data[wzi_pkg::ZCNT_W-1:0];
                wzi_pkg::REG_V_ZONES:      vz_reg    <= cfg_data[wzi_pkg::ZCNT_W-1:0];
                wzi_pkg::REG_WIND_LIMIT:   wl_reg    <= cfg_data;
                wzi_pkg::REG_CHANGE_LIMIT: cl_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // dispatch: a query runs both lanes, an update only the addressed axis
    assign in_stall = busy_reg;
    assign accept   = in_valid && !in_stall;
    assign live     = accept && (req_type != wzi_pkg::REQ_NONE);
    assign is_query = req_type == wzi_pkg::REQ_QUERY;

    // merge: wait for every lane in use, then fill the output register
    assign res_ready = busy_reg && (!need_x_reg || rsp_x.done) && (!need_y_reg || rsp_y.done);
    assign load      = res_ready && (!out_valid_reg || !out_stall);

    assign ctl_x.go  = live && (is_query || !axis_sel);
    assign ctl_x.op  = req_type;
    assign ctl_x.ack = load;
    assign ctl_y.go  = live && (is_query || axis_sel);
    assign ctl_y.op  = req_type;
    assign ctl_y.ack = load;

    wzi_lane #(
        .MAX_ZONES(MAX_ZONES)
    ) u_lane_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_x),
        .pos          (pos_x),
        .screen       (scr_w_reg),
        .zones        (hz_reg),
        .wind_limit   (wl_reg),
        .change_limit (cl_reg),
        .zone_index   (zone_index),
        .rand_sample  (rand_sample),
        .load_value   (load_value),
        .rsp          (rsp_x)
    );

    wzi_lane #(
        .MAX_ZONES(MAX_ZONES)
    ) u_lane_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_y),
        .pos          (pos_y),
        .screen       (scr_h_reg),
        .zones        (vz_reg),
        .wind_limit   (wl_reg),
        .change_limit (cl_reg),
        .zone_index   (zone_index),
        .rand_sample  (rand_sample),
        .load_value   (load_value),
        .rsp          (rsp_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            need_x_reg    <= 1'b0;
            need_y_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (live)
            begin
                busy_reg   <= 1'b1;
                need_x_reg <= ctl_x.go;
                need_y_reg <= ctl_y.go;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload side
    always_ff @(posedge clk)
    begin
        if (live)
        begin
            query_reg <= is_query;
            axis_reg  <= axis_sel;
        end
        if (load)
        begin
            wind_x_reg     <= query_reg ? rsp_x.value : '0;
            wind_y_reg     <= query_reg ? rsp_y.value : '0;
            zone_value_reg <= query_reg ? '0 : (axis_reg ? rsp_y.value : rsp_x.value);
        end
    end

    assign out_valid  = out_valid_reg;
    assign wind_x     = wind_x_reg;
    assign wind_y     = wind_y_reg;
    assign zone_value = zone_value_reg;

endmodule

// ===== hw/rtl/wzi_checker.sv =====
module wzi_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic [1:0]                            req_type,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [wzi_pkg::VAL_W-1:0]      wind_x,
    input logic signed [wzi_pkg::VAL_W-1:0]      wind_y,
    input logic signed [wzi_pkg::VAL_W-1:0]      zone_value
);

    // a held result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a live beat keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type != wzi_pkg::REQ_NONE |=> in_stall)
        else $error("input open right after a live beat");

    // the input reopens only when a result is handed to the output register
    a_release_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input reopened without a result");

    // a result is either a query answer or an update answer
    a_field_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wind_x == '0 && wind_y == '0) || zone_value == '0)
        else $error("result mixes query and update fields");

endmodule

bind wind_zone_interpolator_core wzi_checker u_wzi_checker (.*);

// ===== tb/wind_zone_interpolator_core_test.sv =====
module wind_zone_interpolator_core_test;

    localparam int NZ        = 8;
    localparam int N_RANDOM  = 900;
    localparam int CYCLE_CAP = 600000;
    localparam int IDLE_WAIT = 120;

    localparam int POS_W      = wzi_pkg::POS_W;
    localparam int ZIDX_W     = wzi_pkg::ZIDX_W;
    localparam int RAND_W     = wzi_pkg::RAND_W;
    localparam int VAL_W      = wzi_pkg::VAL_W;
    localparam int CFG_IDX_W  = wzi_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wzi_pkg::CFG_DATA_W;

    typedef struct {
        logic [1:0]              op;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic                    ax;
        logic [ZIDX_W-1:0]       zi;
        logic [RAND_W-1:0]       rs;
        logic signed [VAL_W-1:0] lv;
    } wind_req_t;

    typedef struct {
        logic signed [VAL_W-1:0] wx;
        logic signed [VAL_W-1:0] wy;
        logic signed [VAL_W-1:0] zv;
    } wind_rsp_t;

    // directed table row: request plus optional typed-in answer
    typedef struct {
        wind_req_t req;
        logic      fixed;
        wind_rsp_t rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic axis_sel;
    logic [ZIDX_W-1:0] zone_index;
    logic [RAND_W-1:0] rand_sample;
    logic signed [VAL_W-1:0] load_value;
    logic out_valid;
    logic out_stall;
    logic signed [VAL_W-1:0] wind_x;
    logic signed [VAL_W-1:0] wind_y;
    logic signed [VAL_W-1:0] zone_value;

    wind_zone_interpolator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
        .axis_sel(axis_sel), .zone_index(zone_index),
        .rand_sample(rand_sample), .load_value(load_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .wind_x(wind_x), .wind_y(wind_y), .zone_value(zone_value)
    );

    // mirror of the block's registers and zone tables
    int unsigned scr_w, scr_h, hz_cnt, vz_cnt;
    longint wind_lim, chg_lim;
    longint horiz_tab [NZ];
    longint vert_tab [NZ];

    wind_rsp_t pending_winds [$];
    int  errors;
    int  cycles;
    bit  hold_long;     // forces the receiver to stall for a long stretch

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic longint clamp_wind(input longint v);
        if (v > wind_lim) v = wind_lim;
        if (v < -wind_lim) v = -wind_lim;
        return v;
    endfunction

    // linear blend between zone starts, last zone blends toward zone 0
    function automatic longint blend_axis(input longint pos, input int unsigned scr_reg,
                                          input int unsigned zreg, input bit vert);
        longint screen, zones, size, x, a, b, num, den, lo, i, t_i, t_n;
        screen = (scr_reg != 0) ? scr_reg : 1;
        zones = (zreg == 0) ? 1 : ((zreg > NZ) ? NZ : zreg);
        size = screen / zones;
        x = pos;
        if (x < 0) x = 0;
        if (x >= screen) x = screen - 1;
        for (i = zones - 1; i > 0; i--)
            if (x > i * size) break;
        lo = i * size;
        t_i = vert ? vert_tab[i] : horiz_tab[i];
        if (x == lo) return t_i;
        a = x - lo;
        if (i >= zones - 1)
        begin
            b = screen - x;
            t_n = vert ? vert_tab[0] : horiz_tab[0];
        end
        else
        begin
            b = (i + 1) * size - x;
            t_n = vert ? vert_tab[i + 1] : horiz_tab[i + 1];
        end
        num = b * t_i + a * t_n;
        den = a + b;
        if (den <= 0) return t_i;
        return num / den;
    endfunction

    // apply one request to the mirror; returns 0 when no result follows
    function automatic bit predict_wind(input wind_req_t r, output wind_rsp_t e);
        longint nv, delta, old;
        e.wx = '0;
        e.wy = '0;
        e.zv = '0;
        if (r.op == wzi_pkg::REQ_NONE) return 0;
        if (r.op == wzi_pkg::REQ_QUERY)
        begin
            e.wx = VAL_W'(blend_axis(r.px, scr_w, hz_cnt, 1'b0));
            e.wy = VAL_W'(blend_axis(r.py, scr_h, vz_cnt, 1'b1));
            return 1;
        end
        old = r.ax ? vert_tab[r.zi] : horiz_tab[r.zi];
        if (r.op == wzi_pkg::REQ_PERTURB)
        begin
            delta = ((longint'(r.rs) * chg_lim * 2) >>> 16) - chg_lim;
            nv = clamp_wind(old + delta);
        end
        else
            nv = clamp_wind(r.lv);
        if (r.ax) vert_tab[r.zi] = nv;
        else horiz_tab[r.zi] = nv;
        e.zv = VAL_W'(nv);
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            wzi_pkg::REG_SCREEN_W:     scr_w = val & 12'hFFF;
            wzi_pkg::REG_SCREEN_H:     scr_h = val & 12'hFFF;
            wzi_pkg::REG_H_ZONES:      hz_cnt = val & 4'hF;
            wzi_pkg::REG_V_ZONES:      vz_cnt = val & 4'hF;
            wzi_pkg::REG_WIND_LIMIT:   wind_lim = val & 15'h7FFF;
            wzi_pkg::REG_CHANGE_LIMIT: chg_lim = val & 15'h7FFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one input beat; returns with valid still high so bursts run back to back
    task automatic send_beat(input wind_req_t r);
        wind_rsp_t e;
        @(negedge clk);
        in_valid    <= 1'b1;
        req_type    <= r.op;
        pos_x       <= r.px;
        pos_y       <= r.py;
        axis_sel    <= r.ax;
        zone_index  <= r.zi;
        rand_sample <= r.rs;
        load_value  <= r.lv;
        do @(posedge clk); while (in_stall);
        if (predict_wind(r, e)) pending_winds.push_back(e);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // wait until every expected beat is back, then idle so the block settles
    task automatic drain();
        drop_valid();
        while (pending_winds.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    function automatic wind_req_t rand_req();
        wind_req_t r;
        int k;
        k = $urandom_range(0, 19);
        r.op = (k < 9) ? wzi_pkg::REQ_QUERY : (k < 14) ? wzi_pkg::REQ_PERTURB :
               (k < 19) ? wzi_pkg::REQ_SET : wzi_pkg::REQ_NONE;
        // mostly on-screen positions, sometimes anywhere in the field
        if ($urandom_range(0, 3) == 0)
        begin
            r.px = POS_W'($urandom);
            r.py = POS_W'($urandom);
        end
        else
        begin
            r.px = POS_W'($urandom_range(0, (scr_w == 0) ? 1 : scr_w));
            r.py = POS_W'($urandom_range(0, (scr_h == 0) ? 1 : scr_h));
        end
        r.ax = 1'($urandom);
        r.zi = ZIDX_W'($urandom);
        r.rs = RAND_W'($urandom);
        r.lv = VAL_W'($urandom);
        return r;
    endfunction

    function automatic wind_req_t mk(input logic [1:0] op, input int px, input int py,
                                     input bit ax, input int zi, input int rs, input int lv);
        wind_req_t r;
        r.op = op; r.px = POS_W'(px); r.py = POS_W'(py); r.ax = ax;
        r.zi = ZIDX_W'(zi); r.rs = RAND_W'(rs); r.lv = VAL_W'(lv);
        return r;
    endfunction

    // receiver: random stall pattern, plus a long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_long)
            out_stall <= 1'b1;
        else if (($urandom_range(0, 99) < 40) && (cycles % 600 < 400))
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    // result checker at the rising edge
    always @(posedge clk)
    begin
        wind_rsp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_winds.size() == 0)
            begin
                errors++;
                $display("unexpected result beat: %0d %0d %0d", wind_x, wind_y, zone_value);
            end
            else
            begin
                e = pending_winds.pop_front();
                if (wind_x !== e.wx) report("wind_x", wind_x, e.wx);
                if (wind_y !== e.wy) report("wind_y", wind_y, e.wy);
                if (zone_value !== e.zv) report("zone_value", zone_value, e.zv);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        wind_rsp_t zero_rsp;
        int n, burst, i, z;

        errors = 0;
        cycles = 0;
        hold_long = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; req_type = wzi_pkg::REQ_QUERY; pos_x = '0; pos_y = '0;
        axis_sel = 1'b0; zone_index = '0; rand_sample = '0; load_value = '0;
        scr_w = 640; scr_h = 480; hz_cnt = 3; vz_cnt = 3;
        wind_lim = 0; chg_lim = 0;
        for (z = 0; z < NZ; z++)
        begin
            horiz_tab[z] = 0;
            vert_tab[z] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        zero_rsp.wx = '0; zero_rsp.wy = '0; zero_rsp.zv = '0;

        // directed table: after reset every answer is zero and limits clamp to zero
        row.fixed = 1'b1; row.rsp = zero_rsp;
        row.req = mk(wzi_pkg::REQ_QUERY, -4096, -4096, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 4095, 4095, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 0, 0, 0, 32767); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_PERTURB, 0, 0, 1, 7, 65535, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_NONE, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        foreach (rows[k])
        begin
            send_beat(rows[k].req);
            if (rows[k].fixed && rows[k].req.op != wzi_pkg::REQ_NONE)
                pending_winds[pending_winds.size() - 1] = rows[k].rsp;
        end
        drain();

        // open limits, then predicted rows
        write_reg(wzi_pkg::REG_WIND_LIMIT, 32767);
        write_reg(wzi_pkg::REG_CHANGE_LIMIT, 32767);
        rows.delete();
        row.fixed = 1'b0;
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 0, 0, 0, -32768); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 0, 1, 0, 32767); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 0, 2, 0, 1000); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 1, 0, 0, 500); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 1, 1, 0, -700); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 1, 2, 0, 32767); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_SET, 0, 0, 0, 6, 0, 1234); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_PERTURB, 0, 0, 0, 2, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_PERTURB, 0, 0, 1, 1, 65535, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_PERTURB, 0, 0, 0, 1, 32768, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 213, 160, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 100, 77, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 600, 470, 0, 0, 0, 0); rows.push_back(row);
        row.req = mk(wzi_pkg::REQ_QUERY, 4095, -1, 0, 0, 0, 0); rows.push_back(row);
        foreach (rows[k]) send_beat(rows[k].req);
        drain();

        // odd geometry: a zero extent, zero and oversized zone counts, more zones than pixels
        write_reg(wzi_pkg::REG_SCREEN_W, 0);
        write_reg(wzi_pkg::REG_SCREEN_H, 5);
        write_reg(wzi_pkg::REG_H_ZONES, 0);
        write_reg(wzi_pkg::REG_V_ZONES, 15);
        send_beat(mk(wzi_pkg::REQ_QUERY, 3, 0, 0, 0, 0, 0));
        send_beat(mk(wzi_pkg::REQ_QUERY, 0, 4, 0, 0, 0, 0));
        send_beat(mk(wzi_pkg::REQ_QUERY, -5, 2, 0, 0, 0, 0));
        drain();

        // random phases over several settings, extremes among them
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(wzi_pkg::REG_SCREEN_W, 4095);
                         write_reg(wzi_pkg::REG_SCREEN_H, 1);
                         write_reg(wzi_pkg::REG_H_ZONES, 8);
                         write_reg(wzi_pkg::REG_V_ZONES, 1);
                         write_reg(wzi_pkg::REG_WIND_LIMIT, 32767);
                         write_reg(wzi_pkg::REG_CHANGE_LIMIT, 32767); end
                1: begin write_reg(wzi_pkg::REG_SCREEN_W, 1);
                         write_reg(wzi_pkg::REG_SCREEN_H, 4095);
                         write_reg(wzi_pkg::REG_H_ZONES, 1);
                         write_reg(wzi_pkg::REG_V_ZONES, 8);
                         write_reg(wzi_pkg::REG_WIND_LIMIT, 0);
                         write_reg(wzi_pkg::REG_CHANGE_LIMIT, 0); end
                default: begin
                    write_reg(wzi_pkg::REG_SCREEN_W, $urandom_range(1, 4095));
                    write_reg(wzi_pkg::REG_SCREEN_H, $urandom_range(1, 4095));
                    write_reg(wzi_pkg::REG_H_ZONES, $urandom_range(0, 15));
                    write_reg(wzi_pkg::REG_V_ZONES, $urandom_range(0, 15));
                    write_reg(wzi_pkg::REG_WIND_LIMIT, $urandom_range(0, 32767));
                    write_reg(wzi_pkg::REG_CHANGE_LIMIT, $urandom_range(0, 32767));
                end
            endcase
            n = 0;
            while (n < N_RANDOM / 6)
            begin
                burst = $urandom_range(1, 12);
                // long receiver hold-off once, while the sender keeps offering
                if (ph == 2 && n == 0)
                    fork
                        begin
                            hold_long = 1'b1;
                            repeat (300) @(posedge clk);
                            @(negedge clk);
                            hold_long = 1'b0;
                        end
                    join_none
                for (i = 0; i < burst; i++)
                begin
                    send_beat(rand_req());
                    n++;
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(0, 40)) @(negedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
